[design/kmst_pkg.sv]
// Package for the Kruskal spanning tree block: sizes, state codes and result type.
package kmst_pkg;

    localparam int DEF_MAX_VERTICES = 16;
    localparam int DEF_MAX_EDGES    = 120;
    localparam logic [4:0] VCOUNT_RESET = 5'd16;
    localparam int VID_W   = 4;
    localparam int WGT_W   = 16;
    localparam int COST_W  = 20;
    localparam int EDGE_W  = 2 * VID_W + WGT_W;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_LKA,
        ST_LKB,
        ST_LKC,
        ST_EMIT,
        ST_MERGE,
        ST_NEXT,
        ST_FINISH
    } kmst_state_t;

    typedef struct packed {
        logic                     edge_valid;
        logic [VID_W-1:0]         from_vertex;
        logic [VID_W-1:0]         to_vertex;
        logic signed [WGT_W-1:0]  edge_weight;
        logic signed [COST_W-1:0] total_cost;
        logic                     last_result;
    } kmst_result_t;

endpackage

[design/kmst_ram.sv]
// Generic simple dual-port RAM with registered read.
module kmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[design/kmst_core.sv]
// Load, sort-by-selection, Kruskal scan and result register of the spanning tree block.
module kmst_core import kmst_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ECW = $clog2(MAX_EDGES + 1),
    localparam int VW  = $clog2(MAX_VERTICES),
    localparam int LCW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [4:0]               vertex_count,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [VID_W-1:0]         s_row,
    input  logic [VID_W-1:0]         s_col,
    input  logic signed [WGT_W-1:0]  s_weight,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output kmst_result_t             m_result,
    // edge store
    output logic                     e_we,
    output logic [EAW-1:0]           e_waddr,
    output logic [EDGE_W-1:0]        e_wdata,
    output logic [EAW-1:0]           e_raddr,
    input  logic [EDGE_W-1:0]        e_rdata,
    // label store
    output logic                     l_we,
    output logic [VW-1:0]            l_waddr,
    output logic [VW-1:0]            l_wdata,
    output logic [VW-1:0]            l_raddr,
    input  logic [VW-1:0]            l_rdata
);
    kmst_state_t state_reg, state_next;

    logic [ECW-1:0] cnt_reg, pass_reg, sc_addr_reg, sc_idx_reg;
    logic           sc_v_reg;
    logic [LCW-1:0] i_reg, n_reg, j_reg;
    logic [VW-1:0]  mrg_addr_reg;
    logic           mrg_v_reg;

    logic                     best_v_reg, have_prev_reg;
    logic [VID_W-1:0]         best_hi_reg, best_lo_reg;
    logic signed [WGT_W-1:0]  best_w_reg, prev_w_reg;
    logic [ECW-1:0]           best_idx_reg, prev_idx_reg;
    logic [VW-1:0]            la_reg, lb_reg;
    logic signed [COST_W-1:0] cost_reg;
    logic                     pend_v_reg;
    kmst_result_t             pend_reg, out_reg;
    logic                     out_v_reg;

    logic [LCW-1:0] nv;
    logic           in_acc, keep, out_free, push;
    kmst_result_t   push_data;
    logic signed [WGT_W-1:0] rd_w;
    logic           cand;
    logic           scan_done, merge_done, accept_edge;

    assign nv = ({27'd0, vertex_count} > 32'(MAX_VERTICES)) ? LCW'(MAX_VERTICES)
                                                             : LCW'(vertex_count);
    assign in_acc = s_valid && s_ready;
    assign keep = (s_col < s_row) && (32'(s_row) < 32'(nv)) && (s_weight != '0)
                  && (32'(cnt_reg) < 32'(MAX_EDGES));
    assign out_free = !out_v_reg || m_ready;

    assign rd_w = signed'(e_rdata[WGT_W-1:0]);
    // candidate = strictly after the previous pick in (weight, index) order
    assign cand = !have_prev_reg || (rd_w > prev_w_reg)
                  || ((rd_w == prev_w_reg) && (sc_idx_reg > prev_idx_reg));
    assign scan_done = (sc_addr_reg == cnt_reg) && !sc_v_reg;
    assign merge_done = (j_reg == nv) && !mrg_v_reg;
    assign accept_edge = (l_rdata != la_reg) && (32'(n_reg) < MAX_VERTICES - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (in_acc && s_last) state_next = ST_INIT;
            ST_INIT: begin
                if (32'(i_reg) == MAX_VERTICES - 1) begin
                    state_next = (cnt_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:   if (scan_done) state_next = ST_LKA;
            ST_LKA:    state_next = ST_LKB;
            ST_LKB:    state_next = ST_LKC;
            ST_LKC:    state_next = accept_edge ? ST_EMIT : ST_NEXT;
            ST_EMIT:   if (!pend_v_reg || out_free) state_next = ST_MERGE;
            ST_MERGE:  if (merge_done) state_next = ST_NEXT;
            ST_NEXT:   state_next = (pass_reg + 1'b1 == cnt_reg) ? ST_FINISH : ST_SCAN;
            ST_FINISH: if (out_free) state_next = ST_LOAD;
            default:   state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        e_we      = 1'b0;
        e_waddr   = cnt_reg[EAW-1:0];
        e_wdata   = {s_row, s_col, s_weight};
        e_raddr   = sc_addr_reg[EAW-1:0];
        l_we      = 1'b0;
        l_waddr   = i_reg[VW-1:0];
        l_wdata   = i_reg[VW-1:0];
        l_raddr   = j_reg[VW-1:0];
        push      = 1'b0;
        push_data = pend_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                e_we    = in_acc && keep;
            end
            ST_INIT:  l_we = 1'b1;
            ST_LKA:   l_raddr = VW'(best_hi_reg);
            ST_LKB:   l_raddr = VW'(best_lo_reg);
            ST_EMIT:  push = pend_v_reg && out_free;
            ST_MERGE: begin
                l_we    = mrg_v_reg && (l_rdata == lb_reg);
                l_waddr = mrg_addr_reg;
                l_wdata = la_reg;
            end
            ST_FINISH: begin
                push = out_free;
                if (pend_v_reg) begin
                    push_data.last_result = 1'b1;
                end else begin
                    push_data = '{edge_valid: 1'b0, from_vertex: '0, to_vertex: '0,
                                  edge_weight: '0, total_cost: '0, last_result: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (push) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            if (state_reg == ST_LOAD && in_acc && keep) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (state_reg == ST_FINISH && out_free) begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_reg <= push_data;
        end
        case (state_reg)
            ST_LOAD: begin
                i_reg         <= '0;
                pass_reg      <= '0;
                have_prev_reg <= 1'b0;
                pend_v_reg    <= 1'b0;
                cost_reg      <= '0;
                n_reg         <= '0;
                sc_addr_reg   <= '0;
                sc_v_reg      <= 1'b0;
                best_v_reg    <= 1'b0;
            end
            ST_INIT: i_reg <= i_reg + 1'b1;
            ST_SCAN: begin
                if (sc_addr_reg != cnt_reg) begin
                    sc_addr_reg <= sc_addr_reg + 1'b1;
                    sc_idx_reg  <= sc_addr_reg;
                    sc_v_reg    <= 1'b1;
                end else begin
                    sc_v_reg <= 1'b0;
                end
                if (sc_v_reg && cand && (!best_v_reg || rd_w < best_w_reg)) begin
                    best_v_reg   <= 1'b1;
                    best_hi_reg  <= e_rdata[EDGE_W-1 -: VID_W];
                    best_lo_reg  <= e_rdata[WGT_W +: VID_W];
                    best_w_reg   <= rd_w;
                    best_idx_reg <= sc_idx_reg;
                end
            end
            ST_LKB: la_reg <= l_rdata;
            ST_LKC: begin
                lb_reg <= l_rdata;
                j_reg  <= '0;
                mrg_v_reg <= 1'b0;
            end
            ST_EMIT: begin
                if (!pend_v_reg || out_free) begin
                    pend_v_reg <= 1'b1;
                    cost_reg   <= cost_reg + COST_W'(best_w_reg);
                    pend_reg   <= '{edge_valid: 1'b1, from_vertex: best_hi_reg,
                                    to_vertex: best_lo_reg, edge_weight: best_w_reg,
                                    total_cost: cost_reg + COST_W'(best_w_reg),
                                    last_result: 1'b0};
                    n_reg      <= n_reg + 1'b1;
                end
            end
            ST_MERGE: begin
                if (j_reg != nv) begin
                    j_reg        <= j_reg + 1'b1;
                    mrg_addr_reg <= j_reg[VW-1:0];
                    mrg_v_reg    <= 1'b1;
                end else begin
                    mrg_v_reg <= 1'b0;
                end
            end
            ST_NEXT: begin
                pass_reg      <= pass_reg + 1'b1;
                have_prev_reg <= 1'b1;
                prev_w_reg    <= best_w_reg;
                prev_idx_reg  <= best_idx_reg;
                sc_addr_reg   <= '0;
                sc_v_reg      <= 1'b0;
                best_v_reg    <= 1'b0;
            end
            default: ;
        endcase
    end

    assign m_valid  = out_v_reg;
    assign m_result = out_reg;
endmodule

[design/kruskal_min_spanning_tree_top.sv]
// Top level: vertex count register, edge and label stores, Kruskal core.
// Throughput while loading: one matrix entry per cycle; the last entry starts the build.
// Build: init of all MAX_VERTICES labels, then per stored edge a scan of the edge store
// and endpoint label lookups, plus an emit and a relabel pass per tree edge, then a finish step.
// Results pass a pending register and a one-entry output register; stalls add cycles.
// Sync active-low reset clears control state, vertex_count = 16; edge store unreset.
module kruskal_min_spanning_tree_top import kmst_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [4:0]               cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [VID_W-1:0]         s_row,
    input  logic [VID_W-1:0]         s_col,
    input  logic signed [WGT_W-1:0]  s_weight,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_edge_valid,
    output logic [VID_W-1:0]         m_from_vertex,
    output logic [VID_W-1:0]         m_to_vertex,
    output logic signed [WGT_W-1:0]  m_edge_weight,
    output logic signed [COST_W-1:0] m_total_cost,
    output logic                     m_last_result
);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VW  = $clog2(MAX_VERTICES);

    logic [4:0] vcount_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (cfg_we) begin
            vcount_reg <= cfg_wdata;
        end
    end

    logic              e_we, l_we;
    logic [EAW-1:0]    e_waddr, e_raddr;
    logic [EDGE_W-1:0] e_wdata, e_rdata;
    logic [VW-1:0]     l_waddr, l_wdata, l_raddr, l_rdata;
    kmst_result_t      res;

    kmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    kmst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_label_ram (
        .aclk(aclk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr), .rdata(l_rdata)
    );

    kmst_core #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_core (
        .aclk(aclk), .aresetn(aresetn), .vertex_count(vcount_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_row(s_row), .s_col(s_col),
        .s_weight(s_weight), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(res),
        .e_we(e_we), .e_waddr(e_waddr), .e_wdata(e_wdata),
        .e_raddr(e_raddr), .e_rdata(e_rdata),
        .l_we(l_we), .l_waddr(l_waddr), .l_wdata(l_wdata),
        .l_raddr(l_raddr), .l_rdata(l_rdata)
    );

    assign m_edge_valid  = res.edge_valid;
    assign m_from_vertex = res.from_vertex;
    assign m_to_vertex   = res.to_vertex;
    assign m_edge_weight = res.edge_weight;
    assign m_total_cost  = res.total_cost;
    assign m_last_result = res.last_result;
endmodule
